### hdl/fcpa_pkg.sv
package fcpa_pkg;

    // Defaults for the top-level parameters
    localparam int P_MAX_CHUNKS   = 256;
    localparam int P_HEADER_BYTES = 8;

    // Fixed field widths
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 16;
    localparam int TOTAL_W  = 24;
    localparam int BYTES_W  = 24;
    localparam int CIDX_W   = 8;
    localparam int STRIDE_W = SIZE_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE   = 2'd2;

    localparam logic [SIZE_W-1:0] CHUNK_SIZE_RESET = 16'd64;

    // Opcodes
    localparam logic [1:0] OP_POOL_RESET = 2'd0;
    localparam logic [1:0] OP_ALLOCATE   = 2'd1;
    localparam logic [1:0] OP_FREE       = 2'd2;
    localparam logic [1:0] OP_LOOKUP     = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    // Shared divider
    localparam int DVD_W = ADDR_W;
    localparam int DVS_W = STRIDE_W;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } t_div_rsp;

endpackage

### hdl/fcpa_ram.sv
module fcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/fcpa_div.sv
module fcpa_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fcpa_pkg::t_div_req i_req,
    output fcpa_pkg::t_div_rsp o_rsp
);
    import fcpa_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;

    // One quotient bit per cycle, restoring form
    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        n_quo   = {r_quo[DVD_W-2:0], ~diff[DVS_W]};
        n_rem   = diff[DVS_W] ? shifted[DVS_W-1:0] : diff[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

### hdl/fixed_chunk_pool_allocator_top.sv
// States, accept to o_done: lookup EXEC, MUL, ADDR; allocate EXEC, RD, MUL, ADDR;
// rejected allocate EXEC; free, pool reset EXEC, DIV (32-step shared divider).
// One transaction in flight at a time; o_busy drops in the o_done cycle, so the
// next transaction may start there. The receiver cannot stall: o_done is one cycle.
// i_rst_n (synchronous) empties the pool, zeroes the counters and restores the
// configuration reset values; no clearing pass over the free-stack memory.
module fixed_chunk_pool_allocator_top #(
    parameter int MAX_CHUNKS   = fcpa_pkg::P_MAX_CHUNKS,
    parameter int HEADER_BYTES = fcpa_pkg::P_HEADER_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [fcpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fcpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // command
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_opcode,
    input  logic [fcpa_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [fcpa_pkg::ADDR_W-1:0]   i_free_address,
    input  logic [fcpa_pkg::CIDX_W-1:0]   i_chunk_index,
    // result
    output logic                          o_done,
    output logic [fcpa_pkg::ADDR_W-1:0]   o_address,
    output logic [1:0]                    o_status,
    output logic [fcpa_pkg::BYTES_W-1:0]  o_used_bytes,
    output logic [fcpa_pkg::BYTES_W-1:0]  o_peak_bytes
);
    import fcpa_pkg::*;

    // Free stack entries hold chunk indexes; depth and count need one more bit.
    localparam int IDX_W  = $clog2(MAX_CHUNKS);
    localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
    localparam int MUL_W  = (IDX_W > CIDX_W) ? IDX_W : CIDX_W;
    localparam int PROD_W = MUL_W + STRIDE_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADDR = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;

    // Configuration registers
    logic [ADDR_W-1:0]  r_base;
    logic [SIZE_W-1:0]  r_chunk;
    logic [TOTAL_W-1:0] r_total;

    // Pool state
    logic [2:0]         r_state;
    logic [CNT_W-1:0]   r_depth;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_wm;
    logic [BYTES_W-1:0] r_used;
    logic [BYTES_W-1:0] r_peak;

    // Latched transaction
    logic [1:0]         r_op;
    logic [SIZE_W-1:0]  r_req;
    logic [ADDR_W-1:0]  r_faddr;
    logic [CIDX_W-1:0]  r_cidx;

    // Address datapath
    logic [MUL_W-1:0]   r_idx;
    logic [PROD_W-1:0]  r_prod;

    // Result register
    logic               r_done;
    logic [ADDR_W-1:0]  r_addr;
    logic [1:0]         r_status;

    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   offset;
    logic                stride_zero;
    logic [BYTES_W:0]    used_sum;
    logic [BYTES_W-1:0]  used_inc;
    logic [BYTES_W-1:0]  used_dec;
    logic                free_ok;
    logic [CNT_W-1:0]    n_chunks;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [IDX_W-1:0]    ram_rdata;

    // Chunk stride and the offset of a returned payload address from chunk 0.
    assign stride      = STRIDE_W'(r_chunk) + STRIDE_W'(HEADER_BYTES);
    assign stride_zero = (stride == '0);
    assign offset      = r_faddr - r_base - ADDR_W'(HEADER_BYTES);

    // Used count saturates high on allocate and low on free.
    assign used_sum = {1'b0, r_used} + (BYTES_W + 1)'(r_chunk);
    assign used_inc = used_sum[BYTES_W] ? {BYTES_W{1'b1}} : used_sum[BYTES_W-1:0];
    assign used_dec = (r_used >= BYTES_W'(r_chunk)) ? (r_used - BYTES_W'(r_chunk)) : '0;

    // A free is valid only for an exact payload address of a chunk in the pool,
    // and only while the stack has room.
    assign free_ok = (div_rsp.remainder == '0)
                  && (div_rsp.quotient < ADDR_W'(r_count))
                  && (r_depth < r_count);

    // Chunk count after a pool reset, capped at the stack depth.
    assign n_chunks = (div_rsp.quotient > ADDR_W'(MAX_CHUNKS))
                    ? CNT_W'(MAX_CHUNKS) : CNT_W'(div_rsp.quotient);

    // Hand the divider either total_size or the free offset.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = offset;
        div_req.divisor  = stride;
        if (r_state == S_EXEC && !stride_zero) begin
            case (r_op)
                OP_POOL_RESET: begin
                    div_req.start    = 1'b1;
                    div_req.dividend = ADDR_W'(r_total);
                end
                OP_FREE: begin
                    div_req.start = 1'b1;
                end
                default: begin
                    div_req.start = 1'b0;
                end
            endcase
        end
    end

    fcpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Push on a good free, pop address issued in EXEC for an allocate.
    assign ram_we    = (r_state == S_DIV) && div_rsp.done && (r_op == OP_FREE) && free_ok;
    assign ram_waddr = r_depth[IDX_W-1:0];
    assign ram_wdata = div_rsp.quotient[IDX_W-1:0];
    assign ram_raddr = IDX_W'(r_depth - 1'b1);

    fcpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_CHUNKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration writes; an index past the register list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_chunk <= CHUNK_SIZE_RESET;
            r_total <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE_ADDRESS: r_base  <= i_cfg_wdata[ADDR_W-1:0];
                REG_CHUNK_SIZE:   r_chunk <= i_cfg_wdata[SIZE_W-1:0];
                REG_TOTAL_SIZE:   r_total <= i_cfg_wdata[TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold the transaction fields while it is being worked on.
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_op    <= i_opcode;
            r_req   <= i_request_size;
            r_faddr <= i_free_address;
            r_cidx  <= i_chunk_index;
        end
    end

    // Main sequencer.
    //
    // The free stack is never swept after a pool reset. Instead r_wm tracks
    // the lowest stack depth seen since the last pool reset: every slot below
    // it still holds its own index from the reset, and every slot at or above
    // it has been pushed since it was last popped, so the memory is valid there.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_count  <= '0;
            r_wm     <= '0;
            r_used   <= '0;
            r_peak   <= '0;
            r_done   <= 1'b0;
            r_addr   <= '0;
            r_status <= ST_OK;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    case (r_op)
                        OP_POOL_RESET: begin
                            if (stride_zero) begin
                                // zero stride: empty pool, finish now
                                r_count  <= '0;
                                r_depth  <= '0;
                                r_wm     <= '0;
                                r_used   <= '0;
                                r_peak   <= '0;
                                r_addr   <= '0;
                                r_status <= ST_OK;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        OP_ALLOCATE: begin
                            if (r_req != r_chunk) begin
                                r_addr   <= '0;
                                r_status <= ST_MISMATCH;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end else if (r_depth == '0) begin
                                r_addr   <= '0;
                                r_status <= ST_FULL;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                // pop: the read of the top slot is in flight
                                r_depth <= r_depth - 1'b1;
                                r_state <= S_RD;
                            end
                        end
                        OP_FREE: begin
                            if (stride_zero) begin
                                r_addr   <= '0;
                                r_status <= ST_BAD_FREE;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        default: begin
                            // lookup: any index, also beyond the pool
                            r_idx   <= MUL_W'(r_cidx);
                            r_state <= S_MUL;
                        end
                    endcase
                end

                S_RD: begin
                    // take the popped index, untouched slots read as their own index
                    if (r_depth < r_wm) begin
                        r_idx <= MUL_W'(r_depth[IDX_W-1:0]);
                        r_wm  <= r_depth;
                    end else begin
                        r_idx <= MUL_W'(ram_rdata);
                    end
                    r_used <= used_inc;
                    if (used_inc > r_peak) begin
                        r_peak <= used_inc;
                    end
                    r_state <= S_MUL;
                end

                S_MUL: begin
                    r_prod  <= PROD_W'(r_idx) * PROD_W'(stride);
                    r_state <= S_ADDR;
                end

                S_ADDR: begin
                    r_addr   <= r_base + ADDR_W'(r_prod) + ADDR_W'(HEADER_BYTES);
                    r_status <= ST_OK;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end

                S_DIV: begin
                    if (div_rsp.done) begin
                        r_addr  <= '0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_op == OP_POOL_RESET) begin
                            r_count  <= n_chunks;
                            r_depth  <= n_chunks;
                            r_wm     <= n_chunks;
                            r_used   <= '0;
                            r_peak   <= '0;
                            r_status <= ST_OK;
                        end else if (free_ok) begin
                            // push: the slot write goes out this same edge
                            r_depth  <= r_depth + 1'b1;
                            r_used   <= used_dec;
                            r_status <= ST_OK;
                        end else begin
                            r_status <= ST_BAD_FREE;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_address    = r_addr;
    assign o_status     = r_status;
    assign o_used_bytes = r_used;
    assign o_peak_bytes = r_peak;

endmodule

### tb/sv/testbench.sv
module testbench;
    import fcpa_pkg::*;

    localparam int HDR  = P_HEADER_BYTES;
    localparam int MAXC = P_MAX_CHUNKS;
    // Longest command is a free or pool reset; give it a margin at the end.
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 150;

    // One command transaction as presented on the input ports.
    typedef struct packed {
        logic [1:0]        op;
        logic [SIZE_W-1:0] req;
        logic [ADDR_W-1:0] faddr;
        logic [CIDX_W-1:0] cidx;
    } t_pool_cmd;

    // One reply transaction as seen on the result ports.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [1:0]         status;
        logic [BYTES_W-1:0] used;
        logic [BYTES_W-1:0] peak;
    } t_pool_reply;

    // Row of the directed stimulus table. When typed is set, the reply is
    // taken from the row instead of the pool predictor.
    typedef struct packed {
        t_pool_cmd   cmd;
        logic        typed;
        t_pool_reply want;
    } t_dir_row;

    // ------------------------------------------------------------------
    // DUT inputs: all start at known values
    // ------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata    = '0;
    logic                  i_start        = 1'b0;
    logic [1:0]            i_opcode       = '0;
    logic [SIZE_W-1:0]     i_request_size = '0;
    logic [ADDR_W-1:0]     i_free_address = '0;
    logic [CIDX_W-1:0]     i_chunk_index  = '0;

    logic                  o_busy;
    logic                  o_done;
    logic [ADDR_W-1:0]     o_address;
    logic [1:0]            o_status;
    logic [BYTES_W-1:0]    o_used_bytes;
    logic [BYTES_W-1:0]    o_peak_bytes;

    fixed_chunk_pool_allocator_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_opcode       (i_opcode),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .i_chunk_index  (i_chunk_index),
        .o_done         (o_done),
        .o_address      (o_address),
        .o_status       (o_status),
        .o_used_bytes   (o_used_bytes),
        .o_peak_bytes   (o_peak_bytes)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Pool predictor state: configuration copy, free stack and counters
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  cfg_base   = '0;
    logic [SIZE_W-1:0]  cfg_chunk  = CHUNK_SIZE_RESET;
    logic [TOTAL_W-1:0] cfg_total  = '0;
    logic [CIDX_W-1:0]  fl_stack [MAXC];
    logic [8:0]         fl_depth   = '0;
    logic [8:0]         n_chunks   = '0;
    logic [BYTES_W-1:0] bytes_used = '0;
    logic [BYTES_W-1:0] bytes_peak = '0;

    t_pool_reply        replies_due [$];   // replies owed by the DUT, oldest first
    logic [ADDR_W-1:0]  live_addrs  [$];   // payload addresses currently handed out
    t_dir_row           dir_rows    [$];

    int mismatches = 0;
    int idle_pct   = 6;
    int n_settings = 0;
    int op_count     [4] = '{0, 0, 0, 0};
    int status_count [4] = '{0, 0, 0, 0};

    // Header plus payload: distance between two chunk headers.
    function automatic logic [STRIDE_W-1:0] pool_stride();
        return STRIDE_W'(cfg_chunk) + STRIDE_W'(HDR);
    endfunction

    // Payload address of a chunk; wraps modulo 2^32 like the address bus.
    function automatic logic [ADDR_W-1:0] payload_of(input logic [31:0] idx);
        return cfg_base + idx * ADDR_W'(pool_stride()) + ADDR_W'(HDR);
    endfunction

    // Advance the pool by one command and return the reply it must produce.
    function automatic t_pool_reply pool_apply(input t_pool_cmd c);
        t_pool_reply         r;
        logic [STRIDE_W-1:0] stride;
        logic [ADDR_W-1:0]   off;
        logic [ADDR_W-1:0]   idx;
        logic [BYTES_W:0]    sum;
        logic [TOTAL_W-1:0]  n;
        r      = '0;
        stride = pool_stride();
        case (c.op)
            OP_POOL_RESET: begin
                bytes_used = '0;
                bytes_peak = '0;
                n = (stride != '0) ? cfg_total / TOTAL_W'(stride) : '0;
                if (n > TOTAL_W'(MAXC))
                    n = TOTAL_W'(MAXC);
                // index 0 goes in first, so the highest index pops first
                for (int i = 0; i < n; i++)
                    fl_stack[i] = i[CIDX_W-1:0];
                n_chunks = n[8:0];
                fl_depth = n[8:0];
            end
            OP_ALLOCATE: begin
                // size is checked before emptiness
                if (c.req != cfg_chunk) begin
                    r.status = ST_MISMATCH;
                end else if (fl_depth == '0) begin
                    r.status = ST_FULL;
                end else begin
                    fl_depth   = fl_depth - 9'd1;
                    r.addr     = payload_of(32'(fl_stack[fl_depth[7:0]]));
                    sum        = {1'b0, bytes_used} + (BYTES_W + 1)'(cfg_chunk);
                    bytes_used = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
                    if (bytes_used > bytes_peak)
                        bytes_peak = bytes_used;
                end
            end
            OP_FREE: begin
                off = c.faddr - cfg_base - ADDR_W'(HDR);
                idx = (stride != '0) ? off / ADDR_W'(stride) : '0;
                // reject misaligned, out-of-pool, or a free into an already whole pool
                if (stride != '0 && off % ADDR_W'(stride) == '0 && idx < ADDR_W'(n_chunks)
                        && fl_depth < n_chunks) begin
                    fl_stack[fl_depth[7:0]] = idx[CIDX_W-1:0];
                    fl_depth   = fl_depth + 9'd1;
                    bytes_used = (bytes_used >= BYTES_W'(cfg_chunk))
                               ? bytes_used - BYTES_W'(cfg_chunk) : '0;
                end else begin
                    r.status = ST_BAD_FREE;
                end
            end
            OP_LOOKUP: begin
                r.addr = payload_of(32'(c.cidx));
            end
            default: begin
            end
        endcase
        r.used = bytes_used;
        r.peak = bytes_peak;
        return r;
    endfunction

    function automatic t_pool_cmd mk_cmd(input logic [1:0] op, input logic [SIZE_W-1:0] req,
                                         input logic [ADDR_W-1:0] faddr,
                                         input logic [CIDX_W-1:0] cidx);
        t_pool_cmd c;
        c.op    = op;
        c.req   = req;
        c.faddr = faddr;
        c.cidx  = cidx;
        return c;
    endfunction

    function automatic void add_row(input t_pool_cmd c, input logic typed,
                                    input logic [ADDR_W-1:0] addr, input logic [1:0] status,
                                    input logic [BYTES_W-1:0] used,
                                    input logic [BYTES_W-1:0] peak);
        t_dir_row row;
        row.cmd         = c;
        row.typed       = typed;
        row.want.addr   = addr;
        row.want.status = status;
        row.want.used   = used;
        row.want.peak   = peak;
        dir_rows.push_back(row);
    endfunction

    // Random command, biased toward well-formed traffic: allocates of the
    // configured size and frees of addresses that are really handed out.
    // Unused fields always carry random bits.
    function automatic t_pool_cmd rand_cmd();
        t_pool_cmd c;
        int        pick;
        int        k;
        c.op    = OP_LOOKUP;
        c.req   = SIZE_W'($urandom);
        c.faddr = $urandom;
        c.cidx  = CIDX_W'($urandom);
        pick    = $urandom_range(0, 99);
        if (pick < 3) begin
            c.op = OP_POOL_RESET;
        end else if (pick < 48) begin
            c.op = OP_ALLOCATE;
            k    = $urandom_range(0, 9);
            if (k == 1)
                c.req = cfg_chunk + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
            else if (k != 0)
                c.req = cfg_chunk;
        end else if (pick < 82) begin
            c.op = OP_FREE;
            k    = $urandom_range(0, 9);
            if (k < 7 && live_addrs.size() != 0)
                c.faddr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
            else if (k == 7)
                // a chunk that may already be free, or the one just past the pool
                c.faddr = payload_of($urandom_range(0, n_chunks));
            else if (k == 8)
                c.faddr = payload_of($urandom_range(0, MAXC - 1)) + $urandom_range(1, 3);
        end
        return c;
    endfunction

    // Present one command and hold it until the DUT takes it. Start stays
    // high on return so back-to-back transactions need no extra edge; the
    // caller either issues again or lowers start in this same step.
    task automatic issue(input t_pool_cmd c, input logic typed, input t_pool_reply want);
        t_pool_reply r;
        int          i;
        if ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            // mostly short gaps, some long enough to span a whole divide
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3))
                @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_opcode       <= c.op;
        i_request_size <= c.req;
        i_free_address <= c.faddr;
        i_chunk_index  <= c.cidx;
        do
            @(posedge i_clk);
        while (o_busy);
        // accepted at this edge
        r = pool_apply(c);
        if (c.op == OP_POOL_RESET) begin
            live_addrs.delete();
        end else if (c.op == OP_ALLOCATE && r.status == ST_OK) begin
            live_addrs.push_back(r.addr);
        end else if (c.op == OP_FREE && r.status == ST_OK) begin
            i = 0;
            while (i < live_addrs.size() && live_addrs[i] != c.faddr)
                i++;
            if (i < live_addrs.size())
                live_addrs.delete(i);
        end
        replies_due.push_back(typed ? want : r);
        op_count[c.op]++;
    endtask

    task automatic walk_rows();
        for (int i = 0; i < dir_rows.size(); i++)
            issue(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
        dir_rows.delete();
    endtask

    // Drop start and wait until every owed reply is back.
    task automatic quiesce();
        i_start <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Write all three registers while the pool is idle, one per edge.
    task automatic program_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] chunk,
                                input logic [TOTAL_W-1:0] total);
        quiesce();
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_BASE_ADDRESS;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        cfg_base     = base;
        i_cfg_idx   <= REG_CHUNK_SIZE;
        i_cfg_wdata <= CFG_DATA_W'(chunk);
        @(posedge i_clk);
        cfg_chunk    = chunk;
        i_cfg_idx   <= REG_TOTAL_SIZE;
        i_cfg_wdata <= CFG_DATA_W'(total);
        @(posedge i_clk);
        cfg_total    = total;
        i_cfg_we    <= 1'b0;
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Reply checker: o_done is a one-cycle strobe, sample it at the edge
    // that ends the cycle and compare against the oldest owed reply.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : reply_check
        t_pool_reply want;
        if (i_rst_n && o_done) begin
            if (replies_due.size() == 0) begin
                $error("unexpected reply: address %0h status %0d used %0d peak %0d",
                       o_address, o_status, o_used_bytes, o_peak_bytes);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                status_count[want.status]++;
                if (o_address !== want.addr) begin
                    $error("address: expected %0h, got %0h", want.addr, o_address);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_used_bytes !== want.used) begin
                    $error("used_bytes: expected %0d, got %0d", want.used, o_used_bytes);
                    mismatches++;
                end
                if (o_peak_bytes !== want.peak) begin
                    $error("peak_bytes: expected %0d, got %0d", want.peak, o_peak_bytes);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [ADDR_W-1:0]   base;
        logic [SIZE_W-1:0]   chunk;
        logic [TOTAL_W-1:0]  total;
        logic [STRIDE_W-1:0] s;
        logic [63:0]         t;
        int                  m;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults after reset: base 0, 64-byte chunks, no pool bytes,
        // so nothing can be handed out yet. Stride is 72.
        add_row(mk_cmd(OP_ALLOCATE, 16'd64, 32'hFFFF_FFFF, 8'hFF), 1'b1, 32'd0, ST_FULL,
                24'd0, 24'd0);
        add_row(mk_cmd(OP_ALLOCATE, 16'hFFFF, 32'd0, 8'd0), 1'b1, 32'd0, ST_MISMATCH,
                24'd0, 24'd0);
        add_row(mk_cmd(OP_ALLOCATE, 16'd0, 32'd0, 8'd0), 1'b1, 32'd0, ST_MISMATCH,
                24'd0, 24'd0);
        add_row(mk_cmd(OP_FREE, 16'd0, 32'd8, 8'd0), 1'b1, 32'd0, ST_BAD_FREE, 24'd0, 24'd0);
        add_row(mk_cmd(OP_FREE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF), 1'b1, 32'd0, ST_BAD_FREE,
                24'd0, 24'd0);
        add_row(mk_cmd(OP_LOOKUP, 16'd0, 32'd0, 8'd0), 1'b1, 32'd8, ST_OK, 24'd0, 24'd0);
        add_row(mk_cmd(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF), 1'b1, 32'd18368, ST_OK,
                24'd0, 24'd0);
        add_row(mk_cmd(OP_POOL_RESET, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF), 1'b1, 32'd0, ST_OK,
                24'd0, 24'd0);
        walk_rows();

        // Four 16-byte chunks (stride 24) placed so the payload addresses wrap
        // through zero: FFFFFFE8, 00000000, 00000018, 00000030.
        program_pool(32'hFFFF_FFE0, 16'd16, 24'd100);
        add_row(mk_cmd(OP_POOL_RESET, 16'd0, 32'd0, 8'd0), 1'b1, 32'd0, ST_OK, 24'd0, 24'd0);
        add_row(mk_cmd(OP_ALLOCATE, 16'd16, 32'd0, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        add_row(mk_cmd(OP_ALLOCATE, 16'd16, 32'd0, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        add_row(mk_cmd(OP_ALLOCATE, 16'd16, 32'd0, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        add_row(mk_cmd(OP_ALLOCATE, 16'd16, 32'd0, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        // pool empty
        add_row(mk_cmd(OP_ALLOCATE, 16'd16, 32'd0, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        // size wins
        add_row(mk_cmd(OP_ALLOCATE, 16'd17, 32'd0, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        add_row(mk_cmd(OP_FREE, 16'd0, 32'h0000_0018, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        // misaligned
        add_row(mk_cmd(OP_FREE, 16'd0, 32'h0000_0019, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        // past pool
        add_row(mk_cmd(OP_FREE, 16'd0, 32'h0000_0048, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        // header
        add_row(mk_cmd(OP_FREE, 16'd0, 32'hFFFF_FFE0, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        add_row(mk_cmd(OP_FREE, 16'd0, 32'h0000_0030, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        add_row(mk_cmd(OP_FREE, 16'd0, 32'h0000_0000, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        add_row(mk_cmd(OP_FREE, 16'd0, 32'hFFFF_FFE8, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        // pool whole
        add_row(mk_cmd(OP_FREE, 16'd0, 32'h0000_0030, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        add_row(mk_cmd(OP_LOOKUP, 16'd0, 32'd0, 8'hFF), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        add_row(mk_cmd(OP_ALLOCATE, 16'd16, 32'd0, 8'd0), 1'b0, 32'd0, ST_OK, 24'd0, 24'd0);
        walk_rows();

        // Random phases, each under its own register setting and opened by a
        // pool reset. The first three pin the extremes; phases 3 and 4 run
        // without any gaps on the command side.
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin
                    base  = 32'hFFFF_FFFF;
                    chunk = 16'd1;
                    total = 24'hFF_FFFF;          // count clamps at the maximum
                end
                1: begin
                    base  = 32'd0;
                    chunk = 16'hFFFF;
                    total = 24'hFF_FFFF;
                end
                2: begin
                    base  = $urandom;
                    chunk = SIZE_W'($urandom_range(1, 64));
                    total = 24'd0;                // empty pool
                end
                default: begin
                    base  = $urandom;
                    chunk = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(1, 65535))
                                                        : SIZE_W'($urandom_range(1, 48));
                    s     = STRIDE_W'(chunk) + STRIDE_W'(HDR);
                    m     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 300)
                                                        : $urandom_range(0, 24);
                    t     = 64'(m) * 64'(s) + 64'($urandom_range(0, 32'(s) - 1));
                    total = (t > 64'hFF_FFFF) ? 24'hFF_FFFF : t[TOTAL_W-1:0];
                end
            endcase
            program_pool(base, chunk, total);
            idle_pct = (p == 3 || p == 4) ? 0 : 6;
            issue(mk_cmd(OP_POOL_RESET, SIZE_W'($urandom), $urandom, CIDX_W'($urandom)),
                  1'b0, '0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                issue(rand_cmd(), 1'b0, '0);
        end

        // Drive the used count into its upper clamp: fill a full-size pool with
        // the largest chunks, hand back a few at a tiny chunk size, then take
        // them again at the large size.
        program_pool(32'd0, 16'd1, 24'hFF_FFFF);
        issue(mk_cmd(OP_POOL_RESET, SIZE_W'($urandom), $urandom, CIDX_W'($urandom)), 1'b0, '0);
        program_pool(32'd0, 16'hFFFF, 24'hFF_FFFF);
        for (int i = 0; i <= MAXC; i++)
            issue(mk_cmd(OP_ALLOCATE, 16'hFFFF, $urandom, CIDX_W'($urandom)), 1'b0, '0);
        program_pool(32'd0, 16'd1, 24'hFF_FFFF);
        for (int i = 0; i < 3; i++)
            issue(mk_cmd(OP_FREE, SIZE_W'($urandom), payload_of($urandom_range(0, MAXC - 1)),
                         CIDX_W'($urandom)), 1'b0, '0);
        program_pool(32'd0, 16'hFFFF, 24'hFF_FFFF);
        for (int i = 0; i < 3; i++)
            issue(mk_cmd(OP_ALLOCATE, 16'hFFFF, $urandom, CIDX_W'($urandom)), 1'b0, '0);
        for (int i = 0; i < 4; i++)
            issue(mk_cmd(OP_FREE, SIZE_W'($urandom), payload_of($urandom_range(0, MAXC - 1)),
                         CIDX_W'($urandom)), 1'b0, '0);

        // And into its lower clamp: take small chunks, return them as large ones.
        program_pool(32'h8000_0000, 16'd1, 24'hFF_FFFF);
        issue(mk_cmd(OP_POOL_RESET, SIZE_W'($urandom), $urandom, CIDX_W'($urandom)), 1'b0, '0);
        for (int i = 0; i < 3; i++)
            issue(mk_cmd(OP_ALLOCATE, 16'd1, $urandom, CIDX_W'($urandom)), 1'b0, '0);
        program_pool(32'h8000_0000, 16'hFFFF, 24'hFF_FFFF);
        for (int i = 0; i < 3; i++)
            issue(mk_cmd(OP_FREE, SIZE_W'($urandom), payload_of($urandom_range(0, MAXC - 1)),
                         CIDX_W'($urandom)), 1'b0, '0);

        quiesce();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("pool commands: %0d resets, %0d allocates, %0d frees, %0d lookups over %0d settings",
                 op_count[OP_POOL_RESET], op_count[OP_ALLOCATE], op_count[OP_FREE],
                 op_count[OP_LOOKUP], n_settings);
        $display("replies checked: %0d ok, %0d full, %0d size mismatch, %0d bad free",
                 status_count[ST_OK], status_count[ST_FULL], status_count[ST_MISMATCH],
                 status_count[ST_BAD_FREE]);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop: several times the slowest legal run (every command a full
    // divide plus the longest gap).
    initial begin : watchdog
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
